### src/scfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfs_pkg
// shared types and constants for the segmented column fp32 sum core
// ----------------------------------------------------------------------------
package scfs_pkg;

  localparam int COLUMN_W      = 13;
  localparam int SEGMENT_W     = 5;
  localparam int FP_W          = 32;
  localparam int NUM_COLUMNS_D = 8192;

  // pipeline depth of one fp32 adder, input to registered sum
  localparam int ADD_LAT = 4;

  localparam logic [FP_W-1:0] FP_POS_ZERO  = 32'h0000_0000;
  localparam logic [FP_W-1:0] FP_CANON_NAN = 32'h7FC0_0000;

  // configuration register byte addresses
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_PAIRED_ORDER = 3'd0;

  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_EMPTY = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [COLUMN_W-1:0]  column;
    logic [SEGMENT_W-1:0] segment;
    logic                 first_row;
    logic                 last_row;
    logic [FP_W-1:0]      value_bits;
  } item_t;

  typedef struct packed {
    logic [COLUMN_W-1:0]  out_column;
    logic [SEGMENT_W-1:0] out_segment;
    logic [FP_W-1:0]      sum_bits;
  } result_t;

endpackage

### src/scfs_fp_add.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfs_fp_add
// pipelined ieee fp32 adder, round to nearest even, subnormals kept
// ----------------------------------------------------------------------------
module scfs_fp_add (
  input  logic                      clk,
  input  logic                      en,
  input  logic [scfs_pkg::FP_W-1:0] a,
  input  logic [scfs_pkg::FP_W-1:0] b,
  output logic [scfs_pkg::FP_W-1:0] sum
);

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] cnt;
    logic       found;
    cnt   = 5'd27;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && v[i]) begin
        cnt   = 5'(26 - i);
        found = 1'b1;
      end
    end
    return cnt;
  endfunction

  // stage 1: unpack, order by magnitude, specials
  logic        swap;
  logic [31:0] big, sml;
  logic [7:0]  ebx, eby, exe, eye;
  logic        nan_in, inf_big, inf_sml;

  logic        r1_sx, r1_sy, r1_sub, r1_spec;
  logic [7:0]  r1_ex, r1_d;
  logic [23:0] r1_mx, r1_my;
  logic [31:0] r1_spec_val;

  always_comb begin
    swap    = a[30:0] < b[30:0];
    big     = swap ? b : a;
    sml     = swap ? a : b;
    ebx     = big[30:23];
    eby     = sml[30:23];
    exe     = (ebx == 8'd0) ? 8'd1 : ebx;
    eye     = (eby == 8'd0) ? 8'd1 : eby;
    nan_in  = (ebx == 8'hFF && big[22:0] != 23'd0) || (eby == 8'hFF && sml[22:0] != 23'd0);
    inf_big = ebx == 8'hFF && big[22:0] == 23'd0;
    inf_sml = eby == 8'hFF && sml[22:0] == 23'd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_sx   <= big[31];
      r1_sy   <= sml[31];
      r1_sub  <= big[31] ^ sml[31];
      r1_ex   <= exe;
      r1_d    <= exe - eye;
      r1_mx   <= {ebx != 8'd0, big[22:0]};
      r1_my   <= {eby != 8'd0, sml[22:0]};
      r1_spec <= nan_in || inf_big;
      if (nan_in || (inf_big && inf_sml && (big[31] != sml[31]))) begin
        r1_spec_val <= scfs_pkg::FP_CANON_NAN;
      end else begin
        r1_spec_val <= big;
      end
    end
  end

  // stage 2: align smaller operand with sticky, add or subtract
  logic [4:0]  al_sh;
  logic [49:0] al_tmp;
  logic [26:0] x27, y27;
  logic [27:0] s_raw;

  logic [27:0] r2_s;
  logic [7:0]  r2_ex;
  logic        r2_sign, r2_zsign, r2_spec;
  logic [31:0] r2_spec_val;

  always_comb begin
    al_sh  = (r1_d > 8'd31) ? 5'd31 : r1_d[4:0];
    al_tmp = {r1_my, 26'd0} >> al_sh;
    y27    = {al_tmp[49:24], |al_tmp[23:0]};
    x27    = {r1_mx, 3'd0};
    if (r1_sub) begin
      s_raw = {1'b0, x27} - {1'b0, y27};
    end else begin
      s_raw = {1'b0, x27} + {1'b0, y27};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_s        <= s_raw;
      r2_ex       <= r1_ex;
      r2_sign     <= r1_sx;
      r2_zsign    <= r1_sx & r1_sy;
      r2_spec     <= r1_spec;
      r2_spec_val <= r1_spec_val;
    end
  end

  // stage 3: normalize, exponent floor keeps subnormals
  logic [4:0]  lz;
  logic [7:0]  lim, nsh;
  logic [26:0] n_norm;
  logic [8:0]  e_norm;

  logic [26:0] r3_n;
  logic [8:0]  r3_e;
  logic        r3_sign, r3_zero, r3_zsign, r3_spec;
  logic [31:0] r3_spec_val;

  always_comb begin
    lz  = lzc27(r2_s[26:0]);
    lim = r2_ex - 8'd1;
    nsh = (8'(lz) > lim) ? lim : 8'(lz);
    if (r2_s[27]) begin
      n_norm = {r2_s[27:2], r2_s[1] | r2_s[0]};
      e_norm = {1'b0, r2_ex} + 9'd1;
    end else begin
      n_norm = r2_s[26:0] << nsh;
      e_norm = {1'b0, r2_ex} - {1'b0, nsh};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r3_n        <= n_norm;
      r3_e        <= e_norm;
      r3_sign     <= r2_sign;
      r3_zero     <= r2_s == 28'd0;
      r3_zsign    <= r2_zsign;
      r3_spec     <= r2_spec;
      r3_spec_val <= r2_spec_val;
    end
  end

  // stage 4: round to nearest even, carry runs into the exponent
  logic [7:0]  ef;
  logic        inc;
  logic [30:0] mag;
  logic [31:0] res;

  always_comb begin
    ef  = r3_n[26] ? r3_e[7:0] : 8'd0;
    inc = r3_n[2] & (r3_n[1] | r3_n[0] | r3_n[3]);
    mag = {ef, r3_n[25:3]} + 31'(inc);
    if (r3_spec) begin
      res = r3_spec_val;
    end else if (r3_zero) begin
      res = {r3_zsign, 31'd0};
    end else if (r3_e >= 9'd255) begin
      res = {r3_sign, 8'hFF, 23'd0};
    end else begin
      res = {r3_sign, mag};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= res;
    end
  end

endmodule

### src/segmented_column_fp32_sum_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_column_fp32_sum_core
// per-column fp32 segment sums, accumulators held in one synchronous memory
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle while columns differ and the output
//   queue has room; a transaction on a column still in the read-add-write loop
//   waits until that loop (memory read, 4 adder stages, write back) is through
// reset: synchronous, clears pipeline valids, output queue and paired_order;
//   accumulator memory is not cleared and needs a first row before use
module segmented_column_fp32_sum_core #(
  parameter int NUM_COLUMNS = scfs_pkg::NUM_COLUMNS_D
) (
  input  logic                         clk,
  input  logic                         rst,
  // item channel
  input  logic                         item_valid,
  output logic                         item_stall,
  input  scfs_pkg::item_t              item,
  // result channel
  output logic                         result_valid,
  input  logic                         result_stall,
  output scfs_pkg::result_t            result,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [scfs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int ADDR_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int LAT    = scfs_pkg::ADD_LAT;

  typedef struct packed {
    logic        parity;
    logic [31:0] odd_acc;
    logic [31:0] even_acc;
  } acc_word_t;

  // side band that rides along the first adder
  typedef struct packed {
    logic                           valid;
    logic                           touch;
    logic                           emit;
    logic [scfs_pkg::COLUMN_W-1:0]  column;
    logic [scfs_pkg::SEGMENT_W-1:0] segment;
    logic [ADDR_W-1:0]              addr;
    logic                           use_b;
    logic                           wr_even_a;
    logic                           wr_odd_a;
    logic [31:0]                    even_v;
    logic [31:0]                    odd_v;
    logic                           par_v;
    logic [31:0]                    b_opnd;
  } a_side_t;

  // side band that rides along the second adder
  typedef struct packed {
    logic                           valid;
    logic                           emit;
    logic [scfs_pkg::COLUMN_W-1:0]  column;
    logic [scfs_pkg::SEGMENT_W-1:0] segment;
    logic                           use_b;
    logic [31:0]                    a_res;
  } b_side_t;

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic paired_order;

  assign pready = 1'b1;
  assign prdata = (paddr == scfs_pkg::ADDR_PAIRED_ORDER) ? {31'd0, paired_order} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      paired_order <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr == scfs_pkg::ADDR_PAIRED_ORDER) begin
      paired_order <= pwdata[0];
    end
  end

  // --------------------------------------------------------------------------
  // output queue (two entries) and pipeline advance
  // --------------------------------------------------------------------------
  scfs_pkg::result_t q0, q1;
  logic [1:0]        q_cnt;
  logic              pop, push, adv;
  scfs_pkg::result_t push_data;

  assign result_valid = q_cnt != 2'd0;
  assign result       = q0;
  assign pop          = result_valid && !result_stall;
  // whole pipeline moves together; it only freezes with two results waiting
  assign adv          = (q_cnt != 2'd2) || pop;

  // --------------------------------------------------------------------------
  // input side, hazard interlock
  // --------------------------------------------------------------------------
  logic [31:0]       in_col_ext;
  logic              in_range, in_touch, hazard, accept;
  logic              s1_valid, s1_touch, s1_emit;
  scfs_pkg::item_t   s1_item;
  logic [ADDR_W-1:0] s1_addr;
  a_side_t           sa [LAT];
  b_side_t           sb [LAT];

  assign in_col_ext = 32'(item.column);
  assign in_range   = in_col_ext < 32'(NUM_COLUMNS);
  assign in_touch   = (item.opcode == scfs_pkg::OP_ACCUM) && in_range;

  // a column already between memory read and write back holds the new one off
  always_comb begin
    hazard = s1_valid && s1_touch && (s1_item.column == item.column);
    for (int k = 0; k < LAT; k++) begin
      if (sa[k].valid && sa[k].touch && (sa[k].column == item.column)) begin
        hazard = 1'b1;
      end
    end
  end

  assign item_stall = !adv || (in_touch && hazard);
  assign accept     = item_valid && !item_stall;

  // --------------------------------------------------------------------------
  // accumulator memory: read on accept, write back after the first adder
  // --------------------------------------------------------------------------
  acc_word_t mem [NUM_COLUMNS];
  acc_word_t rd;
  acc_word_t wr_word;

  always_ff @(posedge clk) begin
    if (adv) begin
      rd <= mem[in_col_ext[ADDR_W-1:0]];
      if (sa[LAT-1].valid && sa[LAT-1].touch) begin
        mem[sa[LAT-1].addr] <= wr_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item  <= item;
      s1_addr  <= in_col_ext[ADDR_W-1:0];
      s1_touch <= in_touch;
      s1_emit  <= (item.opcode == scfs_pkg::OP_EMPTY) || (in_range && item.last_row);
    end
  end

  // --------------------------------------------------------------------------
  // operand selection for the two adds
  // --------------------------------------------------------------------------
  logic [31:0] even_e, odd_e, a_x, a_y;
  logic        par_e;
  a_side_t     s1_side;

  always_comb begin
    even_e  = s1_item.first_row ? scfs_pkg::FP_POS_ZERO : rd.even_acc;
    odd_e   = s1_item.first_row ? scfs_pkg::FP_POS_ZERO : rd.odd_acc;
    par_e   = s1_item.first_row ? 1'b0 : rd.parity;
    a_x     = even_e;
    a_y     = s1_item.value_bits;
    s1_side = '0;
    s1_side.valid   = s1_valid;
    s1_side.touch   = s1_touch;
    s1_side.emit    = s1_emit;
    s1_side.column  = s1_item.column;
    s1_side.segment = s1_item.segment;
    s1_side.addr    = s1_addr;
    s1_side.even_v  = even_e;
    s1_side.odd_v   = odd_e;
    s1_side.b_opnd  = s1_item.value_bits;
    if (s1_item.opcode == scfs_pkg::OP_EMPTY) begin
      // empty segment: +0 + +0 gives the +0 result
      a_x = scfs_pkg::FP_POS_ZERO;
      a_y = scfs_pkg::FP_POS_ZERO;
    end else if (!paired_order) begin
      // sequential: even accumulator carries the running sum
      s1_side.wr_even_a = 1'b1;
      s1_side.odd_v     = rd.odd_acc;
      s1_side.par_v     = rd.parity;
    end else if (!par_e && !s1_item.last_row) begin
      s1_side.wr_even_a = 1'b1;
      s1_side.par_v     = 1'b1;
    end else if (!par_e) begin
      // even position last row: (even + odd) + value
      a_x             = even_e;
      a_y             = odd_e;
      s1_side.use_b   = 1'b1;
      s1_side.par_v   = 1'b1;
    end else begin
      // odd position: odd + value, last row then merges even + odd
      a_x              = odd_e;
      s1_side.wr_odd_a = 1'b1;
      s1_side.par_v    = 1'b0;
      s1_side.use_b    = s1_item.last_row;
      s1_side.b_opnd   = even_e;
    end
  end

  // --------------------------------------------------------------------------
  // first adder and its side band
  // --------------------------------------------------------------------------
  logic [31:0] a_sum, b_sum;

  scfs_fp_add u_add_a (
    .clk (clk),
    .en  (adv),
    .a   (a_x),
    .b   (a_y),
    .sum (a_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) begin
        sa[k].valid <= 1'b0;
      end
    end else if (adv) begin
      sa[0] <= s1_side;
      for (int k = 1; k < LAT; k++) begin
        sa[k] <= sa[k-1];
      end
    end
  end

  always_comb begin
    wr_word.parity   = sa[LAT-1].par_v;
    wr_word.even_acc = sa[LAT-1].wr_even_a ? a_sum : sa[LAT-1].even_v;
    wr_word.odd_acc  = sa[LAT-1].wr_odd_a  ? a_sum : sa[LAT-1].odd_v;
  end

  // --------------------------------------------------------------------------
  // second adder: merge or final value add
  // --------------------------------------------------------------------------
  b_side_t b_in;

  always_comb begin
    b_in.valid   = sa[LAT-1].valid;
    b_in.emit    = sa[LAT-1].emit;
    b_in.column  = sa[LAT-1].column;
    b_in.segment = sa[LAT-1].segment;
    b_in.use_b   = sa[LAT-1].use_b;
    b_in.a_res   = a_sum;
  end

  scfs_fp_add u_add_b (
    .clk (clk),
    .en  (adv),
    .a   (a_sum),
    .b   (sa[LAT-1].b_opnd),
    .sum (b_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) begin
        sb[k].valid <= 1'b0;
      end
    end else if (adv) begin
      sb[0] <= b_in;
      for (int k = 1; k < LAT; k++) begin
        sb[k] <= sb[k-1];
      end
    end
  end

  // adder nans come out canonical already
  assign push_data.out_column  = sb[LAT-1].column;
  assign push_data.out_segment = sb[LAT-1].segment;
  assign push_data.sum_bits    = sb[LAT-1].use_b ? b_sum : sb[LAT-1].a_res;
  assign push = adv && sb[LAT-1].valid && sb[LAT-1].emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b11: q_cnt <= q_cnt;
        2'b10: q_cnt <= q_cnt + 2'd1;
        2'b01: q_cnt <= q_cnt - 2'd1;
        default: q_cnt <= q_cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b11: begin
        if (q_cnt == 2'd1) begin
          q0 <= push_data;
        end else begin
          q0 <= q1;
          q1 <= push_data;
        end
      end
      2'b10: begin
        if (q_cnt == 2'd0) begin
          q0 <= push_data;
        end else begin
          q1 <= push_data;
        end
      end
      2'b01: q0 <= q1;
      default: q0 <= q0;
    endcase
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // interlock: a column never sits twice in the read-add-write loop
  a_one_column_in_loop: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_touch) |->
      !((sa[0].valid && sa[0].touch && sa[0].column == s1_item.column) ||
        (sa[1].valid && sa[1].touch && sa[1].column == s1_item.column) ||
        (sa[2].valid && sa[2].touch && sa[2].column == s1_item.column) ||
        (sa[3].valid && sa[3].touch && sa[3].column == s1_item.column)))
    else $error("column hazard in accumulator loop");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_cnt != 2'd3)
    else $error("output queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && q_cnt == 2'd2) |-> pop)
    else $error("output queue overflow");

  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted transaction lost at memory read");

endmodule

### test/tb_segmented_column_fp32_sum_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segmented_column_fp32_sum_core
// self-checking bench: a directed table of segment sums, then random segment
// streams in both summation orders under several idle and stall mixes; every
// result is compared with a bit-exact fp32 sum predictor kept in this file
// ----------------------------------------------------------------------------
module tb_segmented_column_fp32_sum_core;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 16;   // settles the pipeline after the last expected sum
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 190;

  // directed table row
  typedef struct {
    bit              paired;
    scfs_pkg::item_t it;
    bit              typed;      // expected sum typed in below
    logic [31:0]     sum;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  scfs_pkg::item_t   item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  scfs_pkg::result_t result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [scfs_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state: accumulators per column, plus the open-segment tracking
  // that keeps the stimulus away from never-written entries
  logic [31:0] even_sum[int];
  logic [31:0] odd_sum[int];
  bit          odd_next[int];
  bit          seg_open[int];
  bit          paired_mode;

  scfs_pkg::result_t expected_sums[$];
  table_row_t  directed[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatches = 0;
  int          items_sent = 0;
  int          sums_checked = 0;
  int          quiet_cycles = 0;
  int          col_pool[24];

  segmented_column_fp32_sum_core u_top (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall,
    .result, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // bit-exact fp32 add, round to nearest even, subnormals kept
  function automatic logic [31:0] fp32_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] t;
    logic        sa;
    logic        sb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [27:0] wa;
    logic [27:0] wb;
    logic [27:0] s;
    logic [24:0] m;
    int          e;
    int          eb;
    int          d;
    if (a[30:23] == 8'hff || b[30:23] == 8'hff) begin
      if ((a[30:23] == 8'hff && a[22:0] != 0) || (b[30:23] == 8'hff && b[22:0] != 0))
        return scfs_pkg::FP_CANON_NAN;
      if (a[30:23] == 8'hff && b[30:23] == 8'hff && a[31] != b[31])
        return scfs_pkg::FP_CANON_NAN;
      return (a[30:23] == 8'hff) ? a : b;
    end
    // larger magnitude first
    if (a[30:0] < b[30:0]) begin
      t = a; a = b; b = t;
    end
    sa = a[31];
    sb = b[31];
    ma = {a[30:23] != 0, a[22:0]};
    mb = {b[30:23] != 0, b[22:0]};
    e  = (a[30:23] == 0) ? 1 : int'(a[30:23]);
    eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
    d  = e - eb;
    wa = {1'b0, ma, 3'b000};
    wb = {1'b0, mb, 3'b000};
    // align with guard, round and sticky bits
    if (d >= 27)
      wb = {27'd0, mb != 0};
    else if (d > 0)
      wb = (wb >> d) | 28'((wb & 28'((28'd1 << d) - 28'd1)) != 28'd0);
    s = (sa == sb) ? wa + wb : wa - wb;
    // exact cancellation gives +0, like-signed zeros keep their sign
    if (s == 0)
      return (sa == sb) ? {sa, 31'd0} : scfs_pkg::FP_POS_ZERO;
    if (s[27]) begin
      s = (s >> 1) | 28'(s[0]);
      e++;
    end
    while (!s[26] && e > 1) begin
      s = s << 1;
      e--;
    end
    m = {1'b0, s[26:3]} + 25'(s[2] && (s[1] || s[0] || s[3]));
    if (m[24]) begin
      m = m >> 1;
      e++;
    end
    if (e >= 255)
      return {sa, 8'hff, 23'd0};
    return {sa, m[23] ? 8'(e) : 8'd0, m[22:0]};
  endfunction

  // advance the column state for one transaction; returns 1 when it emits a sum
  function automatic bit column_sum_step(input scfs_pkg::item_t it,
                                         output scfs_pkg::result_t r);
    int          c;
    logic [31:0] s;
    c = int'(it.column);
    s = scfs_pkg::FP_POS_ZERO;
    r = '0;
    if (it.opcode == scfs_pkg::OP_EMPTY) begin
      r = '{it.column, it.segment, scfs_pkg::FP_POS_ZERO};
      return 1'b1;
    end
    if (!paired_mode) begin
      even_sum[c] = fp32_add(it.first_row ? scfs_pkg::FP_POS_ZERO : even_sum[c],
                             it.value_bits);
      s = even_sum[c];
    end else begin
      if (it.first_row) begin
        even_sum[c] = scfs_pkg::FP_POS_ZERO;
        odd_sum[c]  = scfs_pkg::FP_POS_ZERO;
        odd_next[c] = 1'b0;
      end
      if (!odd_next[c]) begin
        if (it.last_row)
          s = fp32_add(fp32_add(even_sum[c], odd_sum[c]), it.value_bits);
        else
          even_sum[c] = fp32_add(even_sum[c], it.value_bits);
      end else begin
        odd_sum[c] = fp32_add(odd_sum[c], it.value_bits);
        if (it.last_row)
          s = fp32_add(even_sum[c], odd_sum[c]);
      end
      odd_next[c] = !odd_next[c];
    end
    if (!it.last_row)
      return 1'b0;
    r = '{it.column, it.segment, s};
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // drive one transaction and wait for its handshake
  task automatic send_item(input scfs_pkg::item_t it, input bit typed,
                           input logic [31:0] sum);
    scfs_pkg::result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    if (column_sum_step(it, r)) begin
      if (typed)
        r.sum_bits = sum;
      expected_sums.push_back(r);
    end
  endtask

  // let every expected sum come back and the pipeline settle
  task automatic drain;
    item_valid <= 1'b0;
    @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] wd, output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= scfs_pkg::ADDR_PAIRED_ORDER;
    pwdata  <= wd;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // mode change only while idle; every column then restarts with a first row
  task automatic set_order(input bit paired);
    logic [31:0] rd;
    drain();
    apb_access(1'b1, {31'd0, paired}, rd);
    apb_access(1'b0, '0, rd);
    if (rd[0] !== paired)
      report_mismatch("paired_order readback", rd, {31'd0, paired});
    paired_mode = paired;
    seg_open.delete();
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] specials[10] = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000,
                                  32'hff80_0000, 32'h7fc0_0000, 32'hffff_ffff,
                                  32'h7f7f_ffff, 32'hff7f_ffff, 32'h0000_0001,
                                  32'h807f_ffff};
    case ($urandom_range(8))
      0, 1, 2: return $urandom;
      3:       return specials[$urandom_range(9)];
      4:       return {1'($urandom), 8'd0, 23'($urandom)};
      5, 6:    return {1'($urandom), 8'($urandom_range(134, 120)), 23'($urandom)};
      7:       return {1'($urandom), 8'($urandom_range(254, 248)), 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(3)), 23'($urandom)};
    endcase
  endfunction

  // mostly well-formed segments over a small column pool, some restarts and
  // empty-segment transactions with fully random fields
  function automatic scfs_pkg::item_t random_item();
    scfs_pkg::item_t it;
    int              c;
    it.value_bits = pick_value();
    it.segment    = 5'($urandom);
    if ($urandom_range(99) < 6) begin
      it.opcode    = scfs_pkg::OP_EMPTY;
      it.column    = 13'($urandom);
      it.first_row = 1'($urandom);
      it.last_row  = 1'($urandom);
      return it;
    end
    c = col_pool[$urandom_range(23)];
    it.opcode    = scfs_pkg::OP_ACCUM;
    it.column    = 13'(c);
    it.first_row = !seg_open.exists(c) || !seg_open[c] || $urandom_range(99) < 3;
    it.last_row  = $urandom_range(3) == 0;
    seg_open[c]  = !it.last_row;
    return it;
  endfunction

  task automatic add_row(input bit paired, input scfs_pkg::opcode_t op, input int col,
                         input int seg, input bit f, input bit l, input logic [31:0] v,
                         input bit typed, input logic [31:0] sum);
    table_row_t row;
    row.paired = paired;
    row.it     = '{op, 13'(col), 5'(seg), f, l, v};
    row.typed  = typed;
    row.sum    = sum;
    directed.push_back(row);
  endtask

  // result side: random stall and in-order compare against the expectations
  always @(posedge clk) begin
    result_stall <= $urandom_range(99) < recv_stall_pct;
    if (!rst && result_valid && !result_stall) begin
      if (expected_sums.size() == 0) begin
        report_mismatch("unexpected sum", result.sum_bits, '0);
      end else begin
        if (result.out_column !== expected_sums[0].out_column)
          report_mismatch("out_column", 32'(result.out_column),
                          32'(expected_sums[0].out_column));
        if (result.out_segment !== expected_sums[0].out_segment)
          report_mismatch("out_segment", 32'(result.out_segment),
                          32'(expected_sums[0].out_segment));
        if (result.sum_bits !== expected_sums[0].sum_bits)
          report_mismatch("sum_bits", result.sum_bits, expected_sums[0].sum_bits);
        void'(expected_sums.pop_front());
        sums_checked++;
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d sums outstanding", expected_sums.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int idle_mix[RANDOM_PHASES]  = '{0, 53, 0, 7, 53, 0};
    int stall_mix[RANDOM_PHASES] = '{0, 0, 53, 7, 0, 53};
    bit order_mix[RANDOM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    paired_mode = 1'b0;

    // sequential order: empty segments at the field extremes, single rows,
    // signed zero, overflow, inf minus inf, subnormal sums, exact cancellation
    add_row(0, scfs_pkg::OP_EMPTY, 0,    0,  0, 0, 32'h0000_0000, 1, scfs_pkg::FP_POS_ZERO);
    add_row(0, scfs_pkg::OP_EMPTY, 8191, 31, 1, 1, 32'hffff_ffff, 1, scfs_pkg::FP_POS_ZERO);
    add_row(0, scfs_pkg::OP_ACCUM, 8191, 31, 1, 1, 32'h3f80_0000, 1, 32'h3f80_0000);
    add_row(0, scfs_pkg::OP_ACCUM, 5,    1,  1, 1, 32'h8000_0000, 1, scfs_pkg::FP_POS_ZERO);
    add_row(0, scfs_pkg::OP_ACCUM, 6,    2,  1, 1, 32'h7f80_0000, 1, 32'h7f80_0000);
    add_row(0, scfs_pkg::OP_ACCUM, 7,    3,  1, 1, 32'h7fff_ffff, 1, scfs_pkg::FP_CANON_NAN);
    add_row(0, scfs_pkg::OP_ACCUM, 1,    4,  1, 0, 32'h7f7f_ffff, 0, '0);
    add_row(0, scfs_pkg::OP_ACCUM, 1,    4,  0, 1, 32'h7f7f_ffff, 1, 32'h7f80_0000);
    add_row(0, scfs_pkg::OP_ACCUM, 2,    5,  1, 0, 32'h0000_0001, 0, '0);
    add_row(0, scfs_pkg::OP_ACCUM, 2,    5,  0, 0, 32'h0000_0001, 0, '0);
    add_row(0, scfs_pkg::OP_ACCUM, 2,    5,  0, 1, 32'h807f_ffff, 0, '0);
    add_row(0, scfs_pkg::OP_ACCUM, 3,    6,  1, 0, 32'h7f80_0000, 0, '0);
    add_row(0, scfs_pkg::OP_ACCUM, 3,    6,  0, 1, 32'hff80_0000, 1, scfs_pkg::FP_CANON_NAN);
    add_row(0, scfs_pkg::OP_ACCUM, 4,    7,  1, 0, 32'h3f80_0000, 0, '0);
    add_row(0, scfs_pkg::OP_ACCUM, 4,    7,  0, 1, 32'hbf80_0000, 1, scfs_pkg::FP_POS_ZERO);
    // paired order: even and odd row counts, single row, empty, nan
    add_row(1, scfs_pkg::OP_ACCUM, 10,   8,  1, 0, 32'h3f80_0000, 0, '0);
    add_row(1, scfs_pkg::OP_ACCUM, 10,   8,  0, 0, 32'h3380_0000, 0, '0);
    add_row(1, scfs_pkg::OP_ACCUM, 10,   8,  0, 0, 32'h3380_0000, 0, '0);
    add_row(1, scfs_pkg::OP_ACCUM, 10,   8,  0, 1, 32'h3380_0000, 0, '0);
    add_row(1, scfs_pkg::OP_ACCUM, 11,   9,  1, 0, 32'h4b80_0000, 0, '0);
    add_row(1, scfs_pkg::OP_ACCUM, 11,   9,  0, 0, 32'h3f80_0000, 0, '0);
    add_row(1, scfs_pkg::OP_ACCUM, 11,   9,  0, 1, 32'h3f80_0000, 0, '0);
    add_row(1, scfs_pkg::OP_ACCUM, 12,   10, 1, 1, 32'h4000_0000, 1, 32'h4000_0000);
    add_row(1, scfs_pkg::OP_EMPTY, 10,   11, 0, 1, 32'h1234_5678, 1, scfs_pkg::FP_POS_ZERO);
    add_row(1, scfs_pkg::OP_ACCUM, 13,   12, 1, 1, 32'hffff_ffff, 1, scfs_pkg::FP_CANON_NAN);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].paired != paired_mode)
        set_order(directed[i].paired);
      send_item(directed[i].it, directed[i].typed, directed[i].sum);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_order(order_mix[p]);
      send_idle_pct  = idle_mix[p];
      recv_stall_pct = stall_mix[p];
      // small pool of columns so segments span many rows, plus the extremes
      foreach (col_pool[k])
        col_pool[k] = (k < 16) ? k : int'($urandom_range(8191));
      col_pool[23] = 8191;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold the sender once until everything outstanding has come back
        if (p == 2 && n == PHASE_ITEMS / 2) begin
          item_valid <= 1'b0;
          @(posedge clk);
          while (expected_sums.size() != 0) @(posedge clk);
        end
        send_item(random_item(), 1'b0, '0);
      end
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain();
    $display("run covered %0d transactions and %0d checked sums", items_sent, sums_checked);
    $display("both summation orders, %0d random phases with mixed idle and stall",
             RANDOM_PHASES);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
